>>> hw/rtl/gnep_pkg.sv
// ----------------------------------------------------------------------------
// gnep_pkg
// types and constants shared by the graph notation edge parser
// ----------------------------------------------------------------------------
`default_nettype none

package gnep_pkg;

  // one character of the notation
  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_item_t;

  // one event per character
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [4:0]  error_code;
    logic [4:0]  edge_from;
    logic [4:0]  edge_to;
    logic [15:0] label_numerator;
    logic [15:0] label_denominator;
    logic        label_infinite;
    logic        label_retrograde;
    logic [5:0]  node_total;
  } out_item_t;

  // strobes from the parser to the connection store
  typedef struct packed {
    logic clear;
    logic inval;
    logic wr;
  } conn_ctrl_t;

  // event kinds
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_NODE  = 2'd1;
  localparam logic [1:0] EV_EDGE  = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // error codes
  localparam logic [4:0] ERR_NONE             = 5'd0;
  localparam logic [4:0] ERR_SPACE_IN_EDGE    = 5'd1;
  localparam logic [4:0] ERR_SPACE_IN_REF     = 5'd2;
  localparam logic [4:0] ERR_SECOND_SLASH     = 5'd3;
  localparam logic [4:0] ERR_SLASH_NO_NUM     = 5'd4;
  localparam logic [4:0] ERR_SLASH_NO_EDGE    = 5'd5;
  localparam logic [4:0] ERR_STAR_IN_REF      = 5'd6;
  localparam logic [4:0] ERR_TILDE_IN_REF     = 5'd7;
  localparam logic [4:0] ERR_TILDE_NO_EDGE    = 5'd8;
  localparam logic [4:0] ERR_TILDE_IN_NUM     = 5'd9;
  localparam logic [4:0] ERR_APOS_NO_INF      = 5'd10;
  localparam logic [4:0] ERR_APOS_IN_REF      = 5'd11;
  localparam logic [4:0] ERR_EARLY_BY_NODE    = 5'd12;
  localparam logic [4:0] ERR_DIGIT_IN_INF     = 5'd13;
  localparam logic [4:0] ERR_DIGIT_NO_EDGE    = 5'd14;
  localparam logic [4:0] ERR_NO_SUCH_NODE     = 5'd15;
  localparam logic [4:0] ERR_SELF_LINK        = 5'd16;
  localparam logic [4:0] ERR_ALREADY_LINKED   = 5'd17;
  localparam logic [4:0] ERR_EARLY_BY_REF     = 5'd18;
  localparam logic [4:0] ERR_LETTER_NO_REF    = 5'd19;
  localparam logic [4:0] ERR_BAD_CHAR         = 5'd20;
  localparam logic [4:0] ERR_NODE_LIMIT       = 5'd21;
  localparam logic [4:0] ERR_LABEL_OVERFLOW   = 5'd22;

  // mode flag bit positions
  localparam int F_EDGE  = 0;
  localparam int F_DEN   = 1;
  localparam int F_VIRT  = 2;
  localparam int F_INF   = 3;
  localparam int F_RETRO = 4;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;

endpackage

`default_nettype wire

>>> hw/rtl/gnep_stream_if.sv
// ----------------------------------------------------------------------------
// gnep_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface gnep_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/graph_notation_edge_parser_unit.sv
// ----------------------------------------------------------------------------
// graph_notation_edge_parser_unit
// character-at-a-time parser for a labelled graph notation
// ----------------------------------------------------------------------------
// Takes one character per clock while the output is not stalled and returns
// exactly one event for it in the next cycle, from an output register; a new
// character is taken whenever that register is empty or is being emptied in
// the same cycle, so a stream with no back-pressure runs at one character per
// cycle. The figure is set by the connection store: the row of the current
// node is read from a registered-read memory the cycle before it is needed,
// with the write of the same cycle forwarded. A start character resets the
// parser and the store at once by clearing per-row valid flags, so no clearing
// pass is needed after reset or start.
`default_nettype none

module graph_notation_edge_parser_unit #(
  parameter int MAX_NODES  = 32,
  parameter int LABEL_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  gnep_stream_if.sink   chars,
  gnep_stream_if.source events
);
  import gnep_pkg::*;

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int RW = (CW > 5) ? CW : 5;
  localparam int LW = LABEL_BITS;
  localparam int AW = LABEL_BITS + 4;

  // parser state
  logic [NW-1:0] cur;
  logic [CW-1:0] count;
  logic [4:0]    flags;
  logic [LW-1:0] num_acc;
  logic [LW-1:0] den_acc;
  logic [1:0]    dig;
  logic [4:0]    err;

  logic [NW-1:0] cur_next;
  logic [CW-1:0] count_next;
  logic [4:0]    flags_next;
  logic [LW-1:0] num_acc_next;
  logic [LW-1:0] den_acc_next;
  logic [1:0]    dig_next;
  logic [4:0]    err_next;

  logic          out_valid;
  out_item_t     out_item;
  out_item_t     res;

  logic          accept;

  // store interface
  conn_ctrl_t    ctrl;
  logic          wr_c;
  logic          inval_c;
  logic [NW-1:0] wr_to;
  logic [NW-1:0] rd_row;
  logic [MAX_NODES-1:0] cur_row;

  // step scratch
  logic [7:0]    c;
  logic          start;
  logic [NW-1:0] s_cur;
  logic [CW-1:0] s_count;
  logic [4:0]    s_flags;
  logic [LW-1:0] s_num;
  logic [LW-1:0] s_den;
  logic [1:0]    s_dig;
  logic [4:0]    s_err;
  logic [4:0]    fcode;
  logic          do_edge;
  logic          fin_ok;
  logic [4:0]    ref5;
  logic [RW-1:0] ref_ext;
  logic [LW-1:0] acc_sel;
  logic [AW-1:0] prod;

  assign accept        = chars.valid && chars.ready;
  assign chars.ready   = !rst && (!out_valid || events.ready);
  assign events.valid  = out_valid;
  assign events.payload = out_item;

  always_comb begin
    c       = chars.payload.ch;
    start   = chars.payload.start_req;
    s_cur   = start ? '0 : cur;
    s_count = start ? '0 : count;
    s_flags = start ? '0 : flags;
    s_num   = start ? '0 : num_acc;
    s_den   = start ? '0 : den_acc;
    s_dig   = start ? '0 : dig;
    s_err   = start ? ERR_NONE : err;

    cur_next     = s_cur;
    count_next   = s_count;
    flags_next   = s_flags;
    num_acc_next = s_num;
    den_acc_next = s_den;
    dig_next     = s_dig;
    err_next     = s_err;

    res     = '0;
    fcode   = ERR_NONE;
    do_edge = 1'b0;
    wr_to   = s_cur;
    wr_c    = 1'b0;
    inval_c = 1'b0;

    fin_ok  = s_flags[F_INF] || (s_dig[0] && !(s_flags[F_DEN] && !s_dig[1]));
    ref5    = 5'(c - CH_A);
    ref_ext = RW'(ref5);
    acc_sel = s_flags[F_DEN] ? s_den : s_num;
    prod    = (AW'(acc_sel) << 3) + (AW'(acc_sel) << 1) + AW'(c[3:0]);

    if (s_err != ERR_NONE) begin
      fcode = s_err;
    end else if (c == CH_SPACE) begin
      flags_next[F_EDGE] = 1'b0;
      flags_next[F_DEN]  = 1'b0;
      if (s_dig[0]) begin
        fcode = ERR_SPACE_IN_EDGE;
      end else if (s_flags[F_VIRT]) begin
        fcode = ERR_SPACE_IN_REF;
      end
    end else if (c == CH_SLASH) begin
      if (!s_flags[F_EDGE]) begin
        fcode = ERR_SLASH_NO_EDGE;
      end else if (s_flags[F_DEN]) begin
        fcode = ERR_SECOND_SLASH;
      end else if (!s_dig[0]) begin
        fcode = ERR_SLASH_NO_NUM;
      end else begin
        flags_next[F_DEN] = 1'b1;
      end
    end else if (c == CH_STAR) begin
      if (s_flags[F_VIRT]) begin
        fcode = ERR_STAR_IN_REF;
      end else begin
        flags_next[F_VIRT] = 1'b1;
      end
    end else if (c == CH_TILDE) begin
      if (s_flags[F_VIRT]) begin
        fcode = ERR_TILDE_IN_REF;
      end else if (!s_flags[F_EDGE]) begin
        fcode = ERR_TILDE_NO_EDGE;
      end else if (s_dig[0]) begin
        fcode = ERR_TILDE_IN_NUM;
      end else begin
        flags_next[F_INF] = 1'b1;
      end
    end else if (c == CH_APOS) begin
      if (!s_flags[F_INF]) begin
        fcode = ERR_APOS_NO_INF;
      end else if (s_flags[F_VIRT]) begin
        fcode = ERR_APOS_IN_REF;
      end else begin
        flags_next[F_RETRO] = 1'b1;
      end
    end else if (c == CH_O && !s_flags[F_VIRT]) begin
      if (s_count >= CW'(MAX_NODES)) begin
        fcode = ERR_NODE_LIMIT;
      end else begin
        count_next = s_count + CW'(1);
        inval_c    = 1'b1;
        wr_to      = NW'(s_count);
        cur_next   = NW'(s_count);
        if (s_flags[F_EDGE]) begin
          if (!fin_ok) begin
            fcode = ERR_EARLY_BY_NODE;
          end else begin
            do_edge = 1'b1;
          end
        end else begin
          flags_next[F_EDGE] = 1'b1;
          res.event_kind     = EV_NODE;
        end
      end
    end else if (c >= CH_0 && c <= CH_9) begin
      if (!s_flags[F_EDGE]) begin
        fcode = ERR_DIGIT_NO_EDGE;
      end else if (s_flags[F_INF]) begin
        fcode = ERR_DIGIT_IN_INF;
      end else if (prod[AW-1:LW] != '0) begin
        fcode = ERR_LABEL_OVERFLOW;
      end else if (s_flags[F_DEN]) begin
        den_acc_next = prod[LW-1:0];
        dig_next[1]  = 1'b1;
      end else begin
        num_acc_next = prod[LW-1:0];
        dig_next[0]  = 1'b1;
      end
    end else if (c >= CH_A && c <= CH_Z) begin
      wr_to = NW'(ref5);
      if (!s_flags[F_VIRT]) begin
        fcode = ERR_LETTER_NO_REF;
      end else if (ref_ext >= RW'(s_count)) begin
        fcode = ERR_NO_SUCH_NODE;
      end else begin
        if (s_flags[F_EDGE]) begin
          if (ref_ext == RW'(s_cur)) begin
            fcode = ERR_SELF_LINK;
          end else if (cur_row[NW'(ref5)]) begin
            fcode = ERR_ALREADY_LINKED;
          end else if (!fin_ok) begin
            fcode = ERR_EARLY_BY_REF;
          end else begin
            do_edge = 1'b1;
          end
        end else begin
          flags_next[F_EDGE] = 1'b1;
        end
        cur_next           = NW'(ref5);
        flags_next[F_VIRT] = 1'b0;
      end
    end else begin
      fcode = ERR_BAD_CHAR;
    end

    if (do_edge && fcode == ERR_NONE) begin
      wr_c                  = 1'b1;
      res.event_kind        = EV_EDGE;
      res.edge_from         = 5'(s_cur);
      res.edge_to           = 5'(wr_to);
      res.label_infinite    = s_flags[F_INF];
      res.label_retrograde  = s_flags[F_INF] && s_flags[F_RETRO];
      res.label_numerator   = s_flags[F_INF] ? 16'd0 : 16'(s_num);
      res.label_denominator = (!s_flags[F_INF] && s_flags[F_DEN]) ? 16'(s_den) : 16'd1;
      flags_next[F_INF]     = 1'b0;
      flags_next[F_RETRO]   = 1'b0;
      flags_next[F_DEN]     = 1'b0;
      num_acc_next          = '0;
      den_acc_next          = '0;
      dig_next              = '0;
    end

    if (fcode != ERR_NONE) begin
      res            = '0;
      res.event_kind = EV_ERROR;
      res.error_code = fcode;
      err_next       = fcode;
      wr_c           = 1'b0;
      inval_c        = 1'b0;
    end
    res.node_total = 6'(count_next);
  end

  assign ctrl.clear = accept && start;
  assign ctrl.inval = accept && inval_c;
  assign ctrl.wr    = accept && wr_c;
  assign rd_row     = accept ? cur_next : cur;

  gnep_conn_mem #(
    .N  (MAX_NODES),
    .NW (NW)
  ) u_conn (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .wr_from   (s_cur),
    .wr_to     (wr_to),
    .inval_row (NW'(s_count)),
    .rd_row    (rd_row),
    .row       (cur_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      count     <= '0;
      flags     <= '0;
      num_acc   <= '0;
      den_acc   <= '0;
      dig       <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cur       <= cur_next;
        count     <= count_next;
        flags     <= flags_next;
        num_acc   <= num_acc_next;
        den_acc   <= den_acc_next;
        dig       <= dig_next;
        err       <= err_next;
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gnep_conn_mem.sv
// ----------------------------------------------------------------------------
// gnep_conn_mem
// connection bit store: two row memories, per-row valid flags, write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module gnep_conn_mem #(
  parameter int N  = 32,
  parameter int NW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  gnep_pkg::conn_ctrl_t ctrl,
  input  logic [NW-1:0]       wr_from,
  input  logic [NW-1:0]       wr_to,
  input  logic [NW-1:0]       inval_row,
  input  logic [NW-1:0]       rd_row,
  output logic [N-1:0]        row
);
  import gnep_pkg::*;

  // mem_a holds from->to, mem_b holds to->from, both indexed by row node
  logic [N-1:0] mem_a [N];
  logic [N-1:0] mem_b [N];

  logic [N-1:0] rowv_a;
  logic [N-1:0] rowv_b;
  logic [N-1:0] rowv_a_eff;
  logic [N-1:0] rowv_b_eff;
  logic [N-1:0] rowv_a_next;
  logic [N-1:0] rowv_b_next;
  logic [N-1:0] inval_mask;

  logic [N-1:0] rd_a;
  logic [N-1:0] rd_b;
  logic         keep_a;
  logic         keep_b;
  logic [N-1:0] fwd_a;
  logic [N-1:0] fwd_b;

  function automatic logic [N-1:0] onehot(input logic [NW-1:0] idx);
    onehot = N'(1) << idx;
  endfunction

  always_comb begin
    inval_mask  = ctrl.inval ? onehot(inval_row) : '0;
    rowv_a_eff  = ctrl.clear ? '0 : (rowv_a & ~inval_mask);
    rowv_b_eff  = ctrl.clear ? '0 : (rowv_b & ~inval_mask);
    rowv_a_next = rowv_a_eff | (ctrl.wr ? onehot(wr_from) : '0);
    rowv_b_next = rowv_b_eff | (ctrl.wr ? onehot(wr_to) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rowv_a <= '0;
      rowv_b <= '0;
      keep_a <= 1'b0;
      keep_b <= 1'b0;
      fwd_a  <= '0;
      fwd_b  <= '0;
    end else begin
      rowv_a <= rowv_a_next;
      rowv_b <= rowv_b_next;
      keep_a <= rowv_a_eff[rd_row];
      keep_b <= rowv_b_eff[rd_row];
      fwd_a  <= (ctrl.wr && (wr_from == rd_row)) ? onehot(wr_to) : '0;
      fwd_b  <= (ctrl.wr && (wr_to == rd_row)) ? onehot(wr_from) : '0;
    end
  end

  // a stale row is overwritten whole, a live row gets one bit set
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      if (!rowv_a_eff[wr_from]) begin
        mem_a[wr_from] <= onehot(wr_to);
      end else begin
        mem_a[wr_from][wr_to] <= 1'b1;
      end
      if (!rowv_b_eff[wr_to]) begin
        mem_b[wr_to] <= onehot(wr_from);
      end else begin
        mem_b[wr_to][wr_from] <= 1'b1;
      end
    end
    rd_a <= mem_a[rd_row];
    rd_b <= mem_b[rd_row];
  end

  assign row = (keep_a ? rd_a : '0) | fwd_a | (keep_b ? rd_b : '0) | fwd_b;

endmodule

`default_nettype wire

>>> hw/rtl/gnep_checker.sv
// ----------------------------------------------------------------------------
// gnep_checker
// port-level checks on the edge parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gnep_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gnep_pkg::out_item_t out_payload
);
  import gnep_pkg::*;

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("event changed while stalled");

  // every character transfer gives an event on the next cycle
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no event after character transfer");

  // an empty output register never blocks the input
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with output register empty");

  // error code present exactly on error events
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_payload.event_kind == EV_ERROR) ==
                   (out_payload.error_code != ERR_NONE)))
    else $error("error code does not match event kind");

endmodule

bind graph_notation_edge_parser_unit gnep_checker u_gnep_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .out_valid   (events.valid),
  .out_ready   (events.ready),
  .out_payload (events.payload)
);

`default_nettype wire
